FILE: rtl/bpm_pkg.sv
// Shared types, register map and event codes for the battery protection monitor.
`timescale 1ns / 1ps

package bpm_pkg;

   // Cells checked out of the four packed in the snapshot (1 to 4).
   localparam int CELL_COUNT = 4;
   localparam int CELL_W     = 16;
   localparam int CELLS_W    = 64;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_BROWNOUT    = 3'd0;
   localparam logic [2:0] REG_OVERVOLTAGE = 3'd1;
   localparam logic [2:0] REG_OVERCURRENT = 3'd2;
   localparam logic [2:0] REG_OVERTEMP    = 3'd3;
   localparam logic [2:0] REG_SPREAD_MAX  = 3'd4;
   localparam logic [2:0] REG_TIMEOUT     = 3'd5;
   localparam logic [2:0] REG_CELL_UNDER  = 3'd6;
   localparam logic [2:0] REG_CELL_OVER   = 3'd7;

   // Beat kinds
   localparam logic KIND_CHECK = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Event codes; flag bit is code minus one
   localparam logic [3:0] EV_NONE        = 4'd0;
   localparam logic [3:0] EV_BROWNOUT    = 4'd1;
   localparam logic [3:0] EV_OVERVOLT    = 4'd2;
   localparam logic [3:0] EV_OVERCURRENT = 4'd3;
   localparam logic [3:0] EV_OVERTEMP    = 4'd4;
   localparam logic [3:0] EV_IMBALANCE   = 4'd5;
   localparam logic [3:0] EV_CELL_UNDER  = 4'd6;
   localparam logic [3:0] EV_CELL_OVER   = 4'd7;
   localparam logic [3:0] EV_TIMEOUT     = 4'd8;

   typedef struct packed {
      logic [15:0]        brownout_mv;
      logic [15:0]        overvoltage_mv;
      logic [17:0]        overcurrent_ma;
      logic signed [11:0] overtemp_decidegrees;
      logic [15:0]        cell_spread_max_mv;
      logic [31:0]        sensor_timeout_ms;
      logic [15:0]        cell_under_mv;
      logic [15:0]        cell_over_mv;
   } cfg_type;

   typedef struct packed {
      logic               kind;
      logic [15:0]        pack_voltage;
      logic signed [17:0] pack_current;
      logic               pack_online;
      logic signed [11:0] room_temperature;
      logic               temp_online;
      logic               cells_online;
      logic [CELLS_W-1:0] cell_voltages;
      logic [15:0]        cell_spread;
      logic [31:0]        now_ms;
      logic [31:0]        last_update_ms;
   } snap_type;

   // Check results handed from the comparator bank to the state update
   typedef struct packed {
      logic [7:0] fire;          // flag order; cell bits are 0 when cells offline
      logic [3:0] count;
      logic [3:0] event_code;    // last firing check in evaluation order
      logic       shutdown_hit;  // cell under or overcurrent fired
   } chk_type;

endpackage

FILE: rtl/bpm_check.sv
// Comparator bank: the eight threshold checks on one snapshot.
`timescale 1ns / 1ps

module bpm_check (
   input  bpm_pkg::cfg_type  cfg,
   input  bpm_pkg::snap_type snap,
   output bpm_pkg::chk_type  chk
);
   import bpm_pkg::*;

   logic [17:0] abs_cur;
   logic [31:0] age;
   logic        under;
   logic        over;
   logic [7:0]  fire;
   logic [3:0]  count;

   // -(-2^17) wraps to 2^17, which is right as an unsigned 18-bit value
   assign abs_cur = snap.pack_current[17] ? 18'(-snap.pack_current)
                                          : 18'(snap.pack_current);
   assign age     = snap.now_ms - snap.last_update_ms;

   always_comb begin
      under = 1'b0;
      over  = 1'b0;
      for (int i = 0; i < CELL_COUNT; i++) begin
         if (snap.cell_voltages[CELL_W*i +: CELL_W] < cfg.cell_under_mv) under = 1'b1;
         if (snap.cell_voltages[CELL_W*i +: CELL_W] > cfg.cell_over_mv)  over  = 1'b1;
      end
   end

   always_comb begin
      fire[0] = snap.pack_online && (snap.pack_voltage < cfg.brownout_mv);
      fire[1] = snap.pack_online && (snap.pack_voltage > cfg.overvoltage_mv);
      fire[2] = snap.pack_online && (abs_cur > cfg.overcurrent_ma);
      fire[3] = snap.temp_online && (snap.room_temperature > cfg.overtemp_decidegrees);
      fire[4] = snap.cells_online && (snap.cell_spread > cfg.cell_spread_max_mv);
      fire[5] = snap.cells_online && under;
      fire[6] = snap.cells_online && over;
      fire[7] = (snap.last_update_ms != 32'd0) && (age > cfg.sensor_timeout_ms);
   end

   always_comb begin
      count = 4'd0;
      for (int i = 0; i < 8; i++) begin
         count = count + 4'(fire[i]);
      end
   end

   // Checks run brownout..overtemp, cell under, cell over, imbalance, timeout;
   // the last one to fire names the event.
   always_comb begin
      chk.fire         = fire;
      chk.count        = count;
      chk.shutdown_hit = fire[5] | fire[2];
      priority if (fire[7]) chk.event_code = EV_TIMEOUT;
      else if (fire[4])     chk.event_code = EV_IMBALANCE;
      else if (fire[6])     chk.event_code = EV_CELL_OVER;
      else if (fire[5])     chk.event_code = EV_CELL_UNDER;
      else if (fire[3])     chk.event_code = EV_OVERTEMP;
      else if (fire[2])     chk.event_code = EV_OVERCURRENT;
      else if (fire[1])     chk.event_code = EV_OVERVOLT;
      else if (fire[0])     chk.event_code = EV_BROWNOUT;
      else                  chk.event_code = EV_NONE;
   end

endmodule

FILE: rtl/battery_protection_monitor.sv
// Top level of the battery protection monitor: CSRs, beat pipeline, event state.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_ready  | one snapshot or clear beat
//   rsp_    | out       | rsp_valid/rsp_ready  | flags, count, events, shutdown, start
//   csr_    | in/out    | APB psel/penable     | eight threshold registers
//
// One beat per cycle unless rsp_ready stalls; beats pass input and result registers.
// Event state updates in the same edge that loads the result, so the next beat
// sees it without a bubble. A stalled result holds; the input register still
// takes one more beat behind it. Reset is synchronous; thresholds return to
// their defaults and all event state but the alert count clears.
`timescale 1ns / 1ps

module battery_protection_monitor (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_kind,
   input  logic [15:0]                      req_pack_voltage,
   input  logic signed [17:0]               req_pack_current,
   input  logic                             req_pack_online,
   input  logic signed [11:0]               req_room_temperature,
   input  logic                             req_temp_online,
   input  logic                             req_cells_online,
   input  logic [bpm_pkg::CELLS_W-1:0]      req_cell_voltages,
   input  logic [15:0]                      req_cell_spread,
   input  logic [31:0]                      req_now_ms,
   input  logic [31:0]                      req_last_update_ms,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_alert_flags,
   output logic [3:0]                       rsp_alert_count,
   output logic [3:0]                       rsp_active_event,
   output logic [3:0]                       rsp_last_event,
   output logic                             rsp_emergency_shutdown,
   output logic [31:0]                      rsp_event_start_time,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bpm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bpm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bpm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import bpm_pkg::*;

   cfg_type    cfg_ff;
   snap_type   snap_ff;
   snap_type   snap_in;
   logic       in_valid_ff;
   logic       out_valid_ff;
   logic       advance;
   logic       csr_wr;
   logic [2:0] csr_idx;

   logic [7:0]  flags_ff,  flags_in;
   logic [3:0]  count_ff,  count_in;
   logic [3:0]  cur_ff,    cur_in;
   logic [3:0]  prev_ff,   prev_in;
   logic        shut_ff,   shut_in;
   logic [31:0] start_ff,  start_in;

   chk_type chk;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brownout_mv          <= 16'd11000;
         cfg_ff.overvoltage_mv       <= 16'd14600;
         cfg_ff.overcurrent_ma       <= 18'd100000;
         cfg_ff.overtemp_decidegrees <= 12'sd600;
         cfg_ff.cell_spread_max_mv   <= 16'd100;
         cfg_ff.sensor_timeout_ms    <= 32'd5000;
         cfg_ff.cell_under_mv        <= 16'd2500;
         cfg_ff.cell_over_mv         <= 16'd3650;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_BROWNOUT:    cfg_ff.brownout_mv          <= csr_pwdata[15:0];
            REG_OVERVOLTAGE: cfg_ff.overvoltage_mv       <= csr_pwdata[15:0];
            REG_OVERCURRENT: cfg_ff.overcurrent_ma       <= csr_pwdata[17:0];
            REG_OVERTEMP:    cfg_ff.overtemp_decidegrees <= csr_pwdata[11:0];
            REG_SPREAD_MAX:  cfg_ff.cell_spread_max_mv   <= csr_pwdata[15:0];
            REG_TIMEOUT:     cfg_ff.sensor_timeout_ms    <= csr_pwdata[31:0];
            REG_CELL_UNDER:  cfg_ff.cell_under_mv        <= csr_pwdata[15:0];
            REG_CELL_OVER:   cfg_ff.cell_over_mv         <= csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_BROWNOUT:    csr_prdata = {16'd0, cfg_ff.brownout_mv};
         REG_OVERVOLTAGE: csr_prdata = {16'd0, cfg_ff.overvoltage_mv};
         REG_OVERCURRENT: csr_prdata = {14'd0, cfg_ff.overcurrent_ma};
         REG_OVERTEMP:    csr_prdata = {{20{cfg_ff.overtemp_decidegrees[11]}},
                                        cfg_ff.overtemp_decidegrees};
         REG_SPREAD_MAX:  csr_prdata = {16'd0, cfg_ff.cell_spread_max_mv};
         REG_TIMEOUT:     csr_prdata = cfg_ff.sensor_timeout_ms;
         REG_CELL_UNDER:  csr_prdata = {16'd0, cfg_ff.cell_under_mv};
         REG_CELL_OVER:   csr_prdata = {16'd0, cfg_ff.cell_over_mv};
      endcase
   end

   // ---------------- beat pipeline ----------------
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      snap_in.kind             = req_kind;
      snap_in.pack_voltage     = req_pack_voltage;
      snap_in.pack_current     = req_pack_current;
      snap_in.pack_online      = req_pack_online;
      snap_in.room_temperature = req_room_temperature;
      snap_in.temp_online      = req_temp_online;
      snap_in.cells_online     = req_cells_online;
      snap_in.cell_voltages    = req_cell_voltages;
      snap_in.cell_spread      = req_cell_spread;
      snap_in.now_ms           = req_now_ms;
      snap_in.last_update_ms   = req_last_update_ms;
   end

   bpm_check u_check (
      .cfg  (cfg_ff),
      .snap (snap_ff),
      .chk  (chk)
   );

   // Next event state for the beat in the input register
   always_comb begin
      flags_in = flags_ff;
      count_in = 4'd0;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      shut_in  = shut_ff;
      start_in = start_ff;
      if (snap_ff.kind == KIND_CLEAR) begin
         shut_in  = 1'b0;
         start_in = 32'd0;
      end else begin
         // cell monitor offline: imbalance, cell under and cell over hold
         flags_in = snap_ff.cells_online ? chk.fire
                                         : {chk.fire[7], flags_ff[6:4], chk.fire[3:0]};
         count_in = chk.count;
         if (chk.count != 4'd0) begin
            cur_in   = chk.event_code;
            prev_in  = chk.event_code;
            shut_in  = shut_ff | chk.shutdown_hit;
            start_in = (start_ff == 32'd0) ? snap_ff.now_ms : start_ff;
         end else begin
            cur_in  = EV_NONE;
            shut_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= 8'd0;
         cur_ff       <= EV_NONE;
         prev_ff      <= EV_NONE;
         shut_ff      <= 1'b0;
         start_ff     <= 32'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance && in_valid_ff) begin
            flags_ff <= flags_in;
            cur_ff   <= cur_in;
            prev_ff  <= prev_in;
            shut_ff  <= shut_in;
            start_ff <= start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         snap_ff <= snap_in;
      end
      if (advance && in_valid_ff) begin
         count_ff <= count_in;
      end
   end

   // State only moves when a result is loaded, so it doubles as the result payload
   assign rsp_valid              = out_valid_ff;
   assign rsp_alert_flags        = flags_ff;
   assign rsp_alert_count        = count_ff;
   assign rsp_active_event       = cur_ff;
   assign rsp_last_event         = prev_ff;
   assign rsp_emergency_shutdown = shut_ff;
   assign rsp_event_start_time   = start_ff;

   // ---------------- assertions ----------------
   a_count_has_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alert_count != 4'd0 |-> rsp_active_event != EV_NONE)
      else $error("alerts counted with no active event");

   a_active_is_last: assert property (@(posedge clock) disable iff (reset)
      cur_ff != EV_NONE |-> prev_ff == cur_ff)
      else $error("active event differs from last event");

   a_shutdown_has_event: assert property (@(posedge clock) disable iff (reset)
      shut_ff |-> cur_ff != EV_NONE)
      else $error("emergency shutdown without an active event");

   a_count_vs_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(rsp_alert_flags) >= int'(rsp_alert_count))
      else $error("alert count exceeds raised flags");

endmodule
